@@ rtl/lwe_decrypt_round_unit_assert.svh @@
// assertion macros for the lwe decrypt round unit
// no dependencies; taken in by the top level with include
`ifndef LWE_DECRYPT_ROUND_UNIT_ASSERT_SVH
`define LWE_DECRYPT_ROUND_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LWEDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwedr implication check failed");
`define LWEDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lwedr next-cycle check failed");
`else
`define LWEDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LWEDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lwedr_pkg.sv @@
// shared types and constants of the lwe decrypt round unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lwedr_pkg;

  localparam int W           = 64;
  localparam int CNT_W       = 11;
  localparam int STEP_W      = 7;
  localparam int MAX_DIM_DEF = 1024;
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic [STEP_W-1:0] STEPS_64  = 7'd63;
  localparam logic [STEP_W-1:0] STEPS_128 = 7'd127;

  localparam logic [1:0] FUNC_KEY  = 2'd0;
  localparam logic [1:0] FUNC_COEF = 2'd1;
  localparam logic [1:0] FUNC_BODY = 2'd2;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_COUNT   = 2'd1;
  localparam logic [1:0] ERR_MODULUS = 2'd2;

  localparam logic [1:0] CFG_Q   = 2'd0;
  localparam logic [1:0] CFG_P   = 2'd1;
  localparam logic [1:0] CFG_DIM = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_W_LD, OP_P_LD, OP_H_LD, OP_D_LD, OP_DIV_STEP,
    OP_A_SAVE, OP_PAD_SAVE, OP_M_LD, OP_MUL_STEP, OP_PAD_ACC, OP_CNT_INC,
    OP_PHASE, OP_THR, OP_ROUND, OP_PROD_STEP, OP_EMIT_OK, OP_EMIT_CNT,
    OP_EMIT_MOD
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_W_LD, S_W_RED, S_W_SAVE, S_P_LD, S_P_RED, S_P_SAVE,
    S_M_LD, S_M_RUN, S_M_ACC, S_CNT, S_PHASE, S_H_LD, S_H_RUN, S_THR,
    S_ROUND, S_X_RUN, S_D_LD, S_D_RUN, S_EMIT, S_ERR_CNT, S_ERR_MOD
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic q_zero;
    logic p_zero;
    logic p_top;
    logic cnt_match;
    logic out_block;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/lwedr_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lwedr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lwedr_dp.sv @@
// datapath: config registers, key store, shared restoring divider,
// modular shift-add multiplier and output register; uses lwedr_pkg, lwedr_ram
`timescale 1ns / 1ps
`default_nettype none
module lwedr_dp #(
  parameter int MAX_DIM = lwedr_pkg::MAX_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lwedr_pkg::cmd_t      cmd,
  output lwedr_pkg::status_t        status,
  input  wire logic [1:0]           in_func,
  input  wire logic [9:0]           in_key_index,
  input  wire logic [63:0]          in_word,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_wdata,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [63:0]               out_message,
  output logic [1:0]                out_error
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [63:0]  q_r, p_r;
  logic [10:0]  dim_r;
  logic [63:0]  w_r, rem_r, quo_r, div_r, a_r, kb_r, acc_r, pad_r, ph_r, h_r, t_r;
  logic [127:0] num_r;
  logic [10:0]  cnt_r;
  logic         kz_r;
  logic         ov_r;
  logic [63:0]  msg_r;
  logic [1:0]   err_r;

  logic [63:0]  rem_nxt, quo_nxt, div_nxt, a_nxt, kb_nxt, acc_nxt, pad_nxt;
  logic [63:0]  ph_nxt, h_nxt, t_nxt, w_nxt, msg_nxt;
  logic [127:0] num_nxt;
  logic [10:0]  cnt_nxt;
  logic         kz_nxt, ov_nxt;
  logic [1:0]   err_nxt;

  logic         take;
  logic         key_we, key_re;
  logic [63:0]  key_rdata;

  // divider step
  logic [63:0]  rem2;
  logic [64:0]  dsub;
  logic         dge;
  // multiplier step
  logic [65:0]  ms, ms1, ms2, q66;
  // pad accumulate
  logic [64:0]  ps, ps1;
  logic [10:0]  cnt_inc;

  assign take   = (cmd.op == lwedr_pkg::OP_TAKE);
  assign key_we = take && (in_func == lwedr_pkg::FUNC_KEY) &&
                  (32'(in_key_index) < 32'(MAX_DIM));
  assign key_re = take && (in_func == lwedr_pkg::FUNC_COEF);

  lwedr_ram #(
    .WIDTH (64),
    .DEPTH (MAX_DIM)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (AW'(in_key_index)),
    .wdata (in_word),
    .re    (key_re),
    .raddr (AW'(cnt_r)),
    .rdata (key_rdata)
  );

  assign rem2 = {rem_r[62:0], num_r[127]};
  assign dsub = {1'b0, rem2} - {1'b0, div_r};
  assign dge  = rem_r[63] || !dsub[64];

  assign q66 = {2'b00, q_r};
  assign ms  = {1'b0, acc_r, 1'b0} + (kb_r[63] ? {2'b00, a_r} : 66'd0);
  assign ms1 = ms - q66;
  assign ms2 = ms - {q66[64:0], 1'b0};

  assign ps  = {1'b0, pad_r} + {1'b0, acc_r};
  assign ps1 = ps - {1'b0, q_r};

  assign cnt_inc = (cnt_r < lwedr_pkg::COUNT_MAX) ? cnt_r + 11'd1 : cnt_r;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    num_nxt = num_r;
    a_nxt   = a_r;
    kb_nxt  = kb_r;
    acc_nxt = acc_r;
    pad_nxt = pad_r;
    ph_nxt  = ph_r;
    h_nxt   = h_r;
    t_nxt   = t_r;
    w_nxt   = w_r;
    cnt_nxt = cnt_r;
    kz_nxt  = kz_r;
    msg_nxt = msg_r;
    err_nxt = err_r;
    ov_nxt  = ov_r && out_stall;
    case (cmd.op)
      lwedr_pkg::OP_TAKE: begin
        w_nxt  = in_word;
        kz_nxt = (32'(cnt_r) >= 32'(MAX_DIM));
      end
      lwedr_pkg::OP_W_LD: begin
        num_nxt = {w_r, 64'd0};
        div_nxt = q_r;
        rem_nxt = '0;
        quo_nxt = '0;
      end
      lwedr_pkg::OP_P_LD: begin
        num_nxt = {pad_r, 64'd0};
        div_nxt = q_r;
        rem_nxt = '0;
        quo_nxt = '0;
      end
      lwedr_pkg::OP_H_LD: begin
        num_nxt = {q_r, 64'd0};
        div_nxt = {p_r[62:0], 1'b0};
        rem_nxt = '0;
        quo_nxt = '0;
      end
      lwedr_pkg::OP_D_LD: begin
        div_nxt = q_r;
        rem_nxt = '0;
        quo_nxt = '0;
      end
      lwedr_pkg::OP_DIV_STEP: begin
        rem_nxt = dge ? dsub[63:0] : rem2;
        quo_nxt = {quo_r[62:0], dge};
        num_nxt = {num_r[126:0], 1'b0};
      end
      lwedr_pkg::OP_A_SAVE:   a_nxt = rem_r;
      lwedr_pkg::OP_PAD_SAVE: pad_nxt = rem_r;
      lwedr_pkg::OP_M_LD: begin
        kb_nxt  = kz_r ? 64'd0 : key_rdata;
        acc_nxt = '0;
      end
      lwedr_pkg::OP_MUL_STEP: begin
        // 2*acc + a lies below 3q
        if (!ms2[65]) begin
          acc_nxt = ms2[63:0];
        end else if (!ms1[65]) begin
          acc_nxt = ms1[63:0];
        end else begin
          acc_nxt = ms[63:0];
        end
        kb_nxt = {kb_r[62:0], 1'b0};
      end
      lwedr_pkg::OP_PAD_ACC: begin
        pad_nxt = ps1[64] ? ps[63:0] : ps1[63:0];
        cnt_nxt = cnt_inc;
      end
      lwedr_pkg::OP_CNT_INC: cnt_nxt = cnt_inc;
      lwedr_pkg::OP_PHASE: begin
        ph_nxt = (a_r >= pad_r) ? a_r - pad_r : a_r - pad_r + q_r;
      end
      lwedr_pkg::OP_THR: begin
        h_nxt = quo_r;
        t_nxt = q_r - quo_r;
      end
      lwedr_pkg::OP_ROUND: begin
        kb_nxt  = (ph_r >= t_r) ? ph_r - t_r : ph_r + h_r;
        num_nxt = '0;
      end
      lwedr_pkg::OP_PROD_STEP: begin
        num_nxt = {num_r[126:0], 1'b0} + (kb_r[63] ? {64'd0, p_r} : 128'd0);
        kb_nxt  = {kb_r[62:0], 1'b0};
      end
      lwedr_pkg::OP_EMIT_OK: begin
        msg_nxt = quo_r;
        err_nxt = lwedr_pkg::ERR_OK;
        ov_nxt  = 1'b1;
        pad_nxt = '0;
        cnt_nxt = '0;
      end
      lwedr_pkg::OP_EMIT_CNT: begin
        msg_nxt = '0;
        err_nxt = lwedr_pkg::ERR_COUNT;
        ov_nxt  = 1'b1;
        pad_nxt = '0;
        cnt_nxt = '0;
      end
      lwedr_pkg::OP_EMIT_MOD: begin
        msg_nxt = '0;
        err_nxt = lwedr_pkg::ERR_MODULUS;
        ov_nxt  = 1'b1;
        pad_nxt = '0;
        cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    num_r <= num_nxt;
    a_r   <= a_nxt;
    kb_r  <= kb_nxt;
    acc_r <= acc_nxt;
    ph_r  <= ph_nxt;
    h_r   <= h_nxt;
    t_r   <= t_nxt;
    w_r   <= w_nxt;
    kz_r  <= kz_nxt;
    msg_r <= msg_nxt;
    err_r <= err_nxt;
    if (!rst_n) begin
      pad_r <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      pad_r <= pad_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= 64'd1024;
      p_r   <= 64'd4;
      dim_r <= 11'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        lwedr_pkg::CFG_Q:   q_r <= cfg_wdata;
        lwedr_pkg::CFG_P:   p_r <= cfg_wdata;
        lwedr_pkg::CFG_DIM: dim_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign status.q_zero    = (q_r == 64'd0);
  assign status.p_zero    = (p_r == 64'd0);
  assign status.p_top     = p_r[63];
  assign status.cnt_match = (cnt_r == dim_r);
  assign status.out_block = ov_r && out_stall;

  assign out_valid   = ov_r;
  assign out_message = msg_r;
  assign out_error   = err_r;

endmodule
`default_nettype wire

@@ rtl/lwedr_ctrl.sv @@
// controller: sequences take, reductions, multiply, rounding and result
// uses lwedr_pkg
`timescale 1ns / 1ps
`default_nettype none
module lwedr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_func,
  output logic                    in_stall,
  input  wire lwedr_pkg::status_t status,
  output lwedr_pkg::cmd_t         cmd
);

  lwedr_pkg::state_t state_r, state_nxt;
  logic [1:0] func_r, func_nxt;
  logic [lwedr_pkg::STEP_W-1:0] step_r, step_nxt;
  logic run;

  assign run = (state_r == lwedr_pkg::S_W_RED) || (state_r == lwedr_pkg::S_P_RED) ||
               (state_r == lwedr_pkg::S_M_RUN) || (state_r == lwedr_pkg::S_H_RUN) ||
               (state_r == lwedr_pkg::S_X_RUN) || (state_r == lwedr_pkg::S_D_RUN);
  assign step_nxt = run ? step_r + 1'b1 : '0;

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    case (state_r)
      lwedr_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          case (in_func)
            lwedr_pkg::FUNC_COEF:
              state_nxt = status.q_zero ? lwedr_pkg::S_CNT : lwedr_pkg::S_W_LD;
            lwedr_pkg::FUNC_BODY: begin
              if (!status.cnt_match) begin
                state_nxt = lwedr_pkg::S_ERR_CNT;
              end else if (status.q_zero || status.p_zero) begin
                state_nxt = lwedr_pkg::S_ERR_MOD;
              end else begin
                state_nxt = lwedr_pkg::S_W_LD;
              end
            end
            default: state_nxt = lwedr_pkg::S_IDLE;
          endcase
        end
      end
      lwedr_pkg::S_W_LD: state_nxt = lwedr_pkg::S_W_RED;
      lwedr_pkg::S_W_RED:
        if (step_r == lwedr_pkg::STEPS_64) state_nxt = lwedr_pkg::S_W_SAVE;
      lwedr_pkg::S_W_SAVE: state_nxt = lwedr_pkg::S_P_LD;
      lwedr_pkg::S_P_LD:   state_nxt = lwedr_pkg::S_P_RED;
      lwedr_pkg::S_P_RED:
        if (step_r == lwedr_pkg::STEPS_64) state_nxt = lwedr_pkg::S_P_SAVE;
      lwedr_pkg::S_P_SAVE:
        state_nxt = (func_r == lwedr_pkg::FUNC_COEF) ? lwedr_pkg::S_M_LD
                                                     : lwedr_pkg::S_PHASE;
      lwedr_pkg::S_M_LD: state_nxt = lwedr_pkg::S_M_RUN;
      lwedr_pkg::S_M_RUN:
        if (step_r == lwedr_pkg::STEPS_64) state_nxt = lwedr_pkg::S_M_ACC;
      lwedr_pkg::S_M_ACC: state_nxt = lwedr_pkg::S_IDLE;
      lwedr_pkg::S_CNT:   state_nxt = lwedr_pkg::S_IDLE;
      lwedr_pkg::S_PHASE: state_nxt = lwedr_pkg::S_H_LD;
      // p with its top bit set makes 2p overflow: half is zero
      lwedr_pkg::S_H_LD:
        state_nxt = status.p_top ? lwedr_pkg::S_THR : lwedr_pkg::S_H_RUN;
      lwedr_pkg::S_H_RUN:
        if (step_r == lwedr_pkg::STEPS_64) state_nxt = lwedr_pkg::S_THR;
      lwedr_pkg::S_THR:   state_nxt = lwedr_pkg::S_ROUND;
      lwedr_pkg::S_ROUND: state_nxt = lwedr_pkg::S_X_RUN;
      lwedr_pkg::S_X_RUN:
        if (step_r == lwedr_pkg::STEPS_64) state_nxt = lwedr_pkg::S_D_LD;
      lwedr_pkg::S_D_LD: state_nxt = lwedr_pkg::S_D_RUN;
      lwedr_pkg::S_D_RUN:
        if (step_r == lwedr_pkg::STEPS_128) state_nxt = lwedr_pkg::S_EMIT;
      lwedr_pkg::S_EMIT, lwedr_pkg::S_ERR_CNT, lwedr_pkg::S_ERR_MOD:
        if (!status.out_block) state_nxt = lwedr_pkg::S_IDLE;
      default: state_nxt = lwedr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = lwedr_pkg::OP_NONE;
    case (state_r)
      lwedr_pkg::S_IDLE:   if (in_valid) cmd.op = lwedr_pkg::OP_TAKE;
      lwedr_pkg::S_W_LD:   cmd.op = lwedr_pkg::OP_W_LD;
      lwedr_pkg::S_P_LD:   cmd.op = lwedr_pkg::OP_P_LD;
      lwedr_pkg::S_H_LD:   cmd.op = lwedr_pkg::OP_H_LD;
      lwedr_pkg::S_D_LD:   cmd.op = lwedr_pkg::OP_D_LD;
      lwedr_pkg::S_W_RED, lwedr_pkg::S_P_RED, lwedr_pkg::S_H_RUN, lwedr_pkg::S_D_RUN:
        cmd.op = lwedr_pkg::OP_DIV_STEP;
      lwedr_pkg::S_W_SAVE: cmd.op = lwedr_pkg::OP_A_SAVE;
      lwedr_pkg::S_P_SAVE: cmd.op = lwedr_pkg::OP_PAD_SAVE;
      lwedr_pkg::S_M_LD:   cmd.op = lwedr_pkg::OP_M_LD;
      lwedr_pkg::S_M_RUN:  cmd.op = lwedr_pkg::OP_MUL_STEP;
      lwedr_pkg::S_M_ACC:  cmd.op = lwedr_pkg::OP_PAD_ACC;
      lwedr_pkg::S_CNT:    cmd.op = lwedr_pkg::OP_CNT_INC;
      lwedr_pkg::S_PHASE:  cmd.op = lwedr_pkg::OP_PHASE;
      lwedr_pkg::S_THR:    cmd.op = lwedr_pkg::OP_THR;
      lwedr_pkg::S_ROUND:  cmd.op = lwedr_pkg::OP_ROUND;
      lwedr_pkg::S_X_RUN:  cmd.op = lwedr_pkg::OP_PROD_STEP;
      lwedr_pkg::S_EMIT:
        if (!status.out_block) cmd.op = lwedr_pkg::OP_EMIT_OK;
      lwedr_pkg::S_ERR_CNT:
        if (!status.out_block) cmd.op = lwedr_pkg::OP_EMIT_CNT;
      lwedr_pkg::S_ERR_MOD:
        if (!status.out_block) cmd.op = lwedr_pkg::OP_EMIT_MOD;
      default: cmd.op = lwedr_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (state_r != lwedr_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwedr_pkg::S_IDLE;
      func_r  <= lwedr_pkg::FUNC_KEY;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      func_r  <= func_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lwe_decrypt_round_unit.sv @@
// a body item skips the division for the half when p has its top bit set, and all
// arithmetic when it ends in an error. each reduction takes 64 steps of the one
// restoring divider, shared with the final 128-bit division; products use the
// bit-serial modular multiplier. one item at a time; a finished result waits in the
// output register while the next item is taken. synchronous active-low reset clears
// control, pad, count and out_valid, and sets q, p and dim to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "lwe_decrypt_round_unit_assert.svh"
module lwe_decrypt_round_unit #(
  parameter int MAX_DIM = lwedr_pkg::MAX_DIM_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [9:0]  in_key_index,
  input  wire logic [63:0] in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_message,
  output logic [1:0]       out_error,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  lwedr_pkg::cmd_t    cmd;
  lwedr_pkg::status_t status;
  logic               emit;

  lwedr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lwedr_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_func      (in_func),
    .in_key_index (in_key_index),
    .in_word      (in_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_message  (out_message),
    .out_error    (out_error)
  );

  assign emit = (cmd.op == lwedr_pkg::OP_EMIT_OK) || (cmd.op == lwedr_pkg::OP_EMIT_CNT) ||
                (cmd.op == lwedr_pkg::OP_EMIT_MOD);

  // a transfer in is exactly a take command
  `LWEDR_ASSERT_IMP(a_take_is_transfer, clk, rst_n, in_valid && !in_stall,
                    cmd.op == lwedr_pkg::OP_TAKE)
  // a new result never overwrites one still held by the consumer
  `LWEDR_ASSERT_IMP(a_no_overwrite, clk, rst_n, emit, !(out_valid && out_stall))
  // a result shows up the cycle after it is produced
  `LWEDR_ASSERT_NXT(a_emit_valid, clk, rst_n, emit, out_valid)
  // an error result carries a zero message
  `LWEDR_ASSERT_IMP(a_err_zero_msg, clk, rst_n,
                    out_valid && (out_error != lwedr_pkg::ERR_OK), out_message == 64'd0)

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// self-checking testbench for lwe_decrypt_round_unit: directed table, then random ciphertexts
// depends on lwedr_pkg and the rtl of the unit; decrypt predictions are computed here
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int KEY_DEPTH = 1024;
  localparam int KEY_FILL = 8;
  localparam int DRAIN_CYCLES = 500;
  localparam int HOLD_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 520;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  code;     // func for items, register index for writes
    logic [9:0]  idx;
    logic [63:0] word;
    bit          typed;
    logic [63:0] t_msg;
    logic [1:0]  t_err;
  } stim_row_t;

  typedef struct {
    logic [63:0] msg;
    logic [1:0]  err;
  } plain_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  in_func;
  logic [9:0]  in_key_index;
  logic [63:0] in_word;
  logic        out_valid, out_stall;
  logic [63:0] out_message;
  logic [1:0]  out_error;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  // predictor state
  logic [63:0] key_mem [KEY_DEPTH];
  logic [63:0] pad_acc;
  logic [10:0] coeff_cnt;
  logic [63:0] mod_q, mod_p;
  logic [10:0] dim_cfg;

  plain_t    plain_expected [$];
  stim_row_t plan [$];
  int  fail_count, checked, items_sent, settings;
  bit  quiet, hold_req;

  lwe_decrypt_round_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_key_index(in_key_index), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_message(out_message), .out_error(out_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] q);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, q}) s = s - {1'b0, q};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
    logic [127:0] t;
    t = {64'd0, a % q} * {64'd0, b};
    t = t % {64'd0, q};
    return t[63:0];
  endfunction

  function automatic void add_item(logic [1:0] f, logic [9:0] i, logic [63:0] w);
    plan.push_back('{ROW_ITEM, f, i, w, 1'b0, 64'd0, lwedr_pkg::ERR_OK});
  endfunction

  function automatic void add_typed(logic [63:0] w, logic [63:0] m, logic [1:0] e);
    plan.push_back('{ROW_ITEM, lwedr_pkg::FUNC_BODY, 10'd0, w, 1'b1, m, e});
  endfunction

  function automatic void add_cfg(logic [1:0] r, logic [63:0] v);
    plan.push_back('{ROW_CFG, r, 10'd0, v, 1'b0, 64'd0, lwedr_pkg::ERR_OK});
  endfunction

  // advances the predictor by one accepted item
  task automatic decrypt_step(input stim_row_t r);
    logic [63:0] k, b, pd, phase, half, rounded;
    logic [127:0] prod;
    plain_t res;
    case (r.code)
      lwedr_pkg::FUNC_KEY: key_mem[r.idx] = r.word;
      lwedr_pkg::FUNC_COEF: begin
        if (mod_q != 0) begin
          k = (coeff_cnt < KEY_DEPTH) ? key_mem[coeff_cnt[9:0]] : 64'd0;
          pad_acc = add_mod(pad_acc % mod_q, mul_mod(r.word, k, mod_q), mod_q);
        end
        if (coeff_cnt != lwedr_pkg::COUNT_MAX) coeff_cnt = coeff_cnt + 1'b1;
      end
      lwedr_pkg::FUNC_BODY: begin
        res = '{64'd0, lwedr_pkg::ERR_OK};
        if (coeff_cnt != dim_cfg) begin
          res.err = lwedr_pkg::ERR_COUNT;
        end else if (mod_q == 0 || mod_p == 0) begin
          res.err = lwedr_pkg::ERR_MODULUS;
        end else begin
          b = r.word % mod_q;
          pd = pad_acc % mod_q;
          phase = (b >= pd) ? b - pd : b + (mod_q - pd);
          half = mod_p[63] ? 64'd0 : mod_q / (mod_p << 1);
          rounded = (phase >= mod_q - half) ? phase - (mod_q - half) : phase + half;
          prod = ({64'd0, mod_p} * {64'd0, rounded}) / {64'd0, mod_q};
          res.msg = prod[63:0];
        end
        if (r.typed) res = '{r.t_msg, r.t_err};
        plain_expected.push_back(res);
        pad_acc = 64'd0;
        coeff_cnt = 11'd0;
      end
      default: ;
    endcase
  endtask

  task automatic send(input stim_row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.code;
    in_key_index <= r.idx;
    in_word <= r.word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decrypt_step(r);
    if (r.code != FUNC_NONE) items_sent++;
  endtask

  // register writes only once the unit has gone quiet
  task automatic write_reg(input logic [1:0] r, input logic [63:0] v);
    in_valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      lwedr_pkg::CFG_Q: mod_q = v;
      lwedr_pkg::CFG_P: mod_p = v;
      lwedr_pkg::CFG_DIM: dim_cfg = v[10:0];
      default: ;
    endcase
    settings++;
  endtask

  task automatic run_row(input stim_row_t r);
    if (r.kind == ROW_CFG) write_reg(r.code, r.word);
    else send(r);
  endtask

  // result checker
  always @(posedge clk) begin
    plain_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (plain_expected.size() == 0) begin
        $error("unexpected result transfer: message %0d error %0d", out_message, out_error);
        fail_count++;
      end else begin
        e = plain_expected.pop_front();
        checked++;
        if (out_message !== e.msg) begin
          $error("message: expected %0d, got %0d", e.msg, out_message);
          fail_count++;
        end
        if (out_error !== e.err) begin
          $error("error: expected %0d, got %0d", e.err, out_error);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet || $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t r;
    int n, seq, len;
    logic [63:0] q;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = lwedr_pkg::FUNC_KEY;
    in_key_index = 10'd0;
    in_word = 64'd0;
    cfg_we = 1'b0;
    cfg_index = lwedr_pkg::CFG_Q;
    cfg_wdata = 64'd0;
    quiet = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;
    checked = 0;
    items_sent = 0;
    settings = 0;
    mod_q = 64'd1024;
    mod_p = 64'd4;
    dim_cfg = 11'd512;
    pad_acc = 64'd0;
    coeff_cnt = 11'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    add_typed(64'd0, 64'd0, lwedr_pkg::ERR_COUNT);
    add_item(FUNC_NONE, 10'd1023, ALL_ONES);
    add_item(lwedr_pkg::FUNC_KEY, 10'd1023, ALL_ONES);
    add_item(lwedr_pkg::FUNC_KEY, 10'd0, 64'd0);
    add_cfg(lwedr_pkg::CFG_DIM, 64'd0);
    add_typed(64'd0, 64'd0, lwedr_pkg::ERR_OK);
    add_typed(64'd300, 64'd1, lwedr_pkg::ERR_OK);
    add_item(lwedr_pkg::FUNC_BODY, 10'd0, ALL_ONES);           // unreduced body
    add_cfg(lwedr_pkg::CFG_P, 64'd0);
    add_typed(64'd7, 64'd0, lwedr_pkg::ERR_MODULUS);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'd5);
    add_typed(64'd7, 64'd0, lwedr_pkg::ERR_COUNT);             // count wins over zero p
    add_cfg(lwedr_pkg::CFG_Q, 64'd0);
    add_cfg(lwedr_pkg::CFG_P, 64'd4);
    add_cfg(lwedr_pkg::CFG_DIM, 64'd2);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'd3);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, ALL_ONES);
    add_typed(64'd9, 64'd0, lwedr_pkg::ERR_MODULUS);
    add_cfg(lwedr_pkg::CFG_Q, ALL_ONES);
    add_cfg(lwedr_pkg::CFG_P, ALL_ONES);                        // half rounds to zero
    add_item(lwedr_pkg::FUNC_KEY, 10'd1, ALL_ONES);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, ALL_ONES);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'd1);
    add_item(lwedr_pkg::FUNC_BODY, 10'd0, 64'h8000_0000_0000_0001);
    add_cfg(lwedr_pkg::CFG_P, 64'h8000_0000_0000_0000);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'h1234_5678_9ABC_DEF0);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(lwedr_pkg::FUNC_BODY, 10'd0, 64'hC000_0000_0000_0000);
    add_cfg(lwedr_pkg::CFG_Q, 64'd1);
    add_cfg(lwedr_pkg::CFG_P, 64'd1);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'd0);
    add_item(lwedr_pkg::FUNC_COEF, 10'd0, 64'd0);
    add_typed(ALL_ONES, 64'd0, lwedr_pkg::ERR_OK);

    // fill the low key entries; coefficient positions never run past them
    for (n = 0; n < KEY_FILL; n++) begin
      r = '{ROW_ITEM, lwedr_pkg::FUNC_KEY, n[9:0], rand64(), 1'b0, 64'd0,
            lwedr_pkg::ERR_OK};
      send(r);
    end
    foreach (plan[i]) run_row(plan[i]);

    // random ciphertexts under changing settings
    n = 0;
    seq = 0;
    while (n < RANDOM_ITEMS) begin
      if (seq % 10 == 0) begin
        case ($urandom_range(0, 4))
          0: q = $urandom_range(1, 4096);
          1: q = ALL_ONES;
          2: q = 64'd1 << $urandom_range(0, 63);
          3: q = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
          default: q = rand64();
        endcase
        write_reg(lwedr_pkg::CFG_Q, q);
        case ($urandom_range(0, 5))
          0: write_reg(lwedr_pkg::CFG_P, rand64());
          1: write_reg(lwedr_pkg::CFG_P, ($urandom_range(0, 3) == 0) ? 64'd0 : ALL_ONES);
          default: write_reg(lwedr_pkg::CFG_P, $urandom_range(1, 16));
        endcase
        write_reg(lwedr_pkg::CFG_DIM, $urandom_range(0, 6));
      end
      if (n > RANDOM_ITEMS - 100) quiet = 1'b1;
      if (seq == 20) hold_req = 1'b1;
      // occasional key rewrites
      repeat ($urandom_range(0, 2)) begin
        r = '{ROW_ITEM, lwedr_pkg::FUNC_KEY, 10'($urandom_range(0, 1023)), rand64(),
              1'b0, 64'd0, lwedr_pkg::ERR_OK};
        send(r);
        n++;
      end
      len = dim_cfg;
      if ($urandom_range(0, 5) == 0) len = len + $urandom_range(0, 2) - 1;
      if (len < 0) len = 0;
      for (int c = 0; c <= len; c++) begin
        r = '{ROW_ITEM, (c == len) ? lwedr_pkg::FUNC_BODY : lwedr_pkg::FUNC_COEF,
              10'($urandom), rand64(), 1'b0, 64'd0, lwedr_pkg::ERR_OK};
        if (mod_q != 0 && $urandom_range(0, 4) != 0) r.word = r.word % mod_q;
        send(r);
        n++;
        if ($urandom_range(0, 15) == 0) begin
          r.code = FUNC_NONE;
          send(r);
        end
      end
      seq++;
    end

    in_valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d items sent, %0d decrypt results compared, %0d register writes",
             items_sent, checked, settings);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
